[src/assert_macros.svh]
// ----------------------------------------------------------------------------
// assert_macros.svh
// Concurrent assertion helpers, compiled out when SYNTH is defined
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef SYNTH
// condition holds at every clock edge outside reset
`define ASSERT_ALWAYS(label, clk, rst, cond, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (cond)) else $error(msg);
// antecedent in one cycle implies consequent in the next
`define ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);
`else
`define ASSERT_ALWAYS(label, clk, rst, cond, msg)
`define ASSERT_NEXT(label, clk, rst, ante, cons, msg)
`endif

`endif

[src/gurc_pkg.sv]
// ----------------------------------------------------------------------------
// gurc_pkg
// Shared types and constants of the guest register cache allocator
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package gurc_pkg;

   // fixed guest register file
   localparam int GUEST_REGS = 32;
   localparam int GUEST_W    = 5;
   // walk index covers every guest register and the guest count itself
   localparam int WALK_W     = GUEST_W + 1;
   localparam int SLOT_OUT_W = 3;

   // parameter defaults
   localparam int HOST_SLOTS_DEF      = 8;
   localparam int PRESERVED_SLOTS_DEF = 4;

   typedef enum logic [1:0] {
      OP_ALLOC = 2'd0,
      OP_DIRTY = 2'd1,
      OP_CALL  = 2'd2,
      OP_FLUSH = 2'd3
   } op_type;

   typedef enum logic [2:0] {
      ACT_NONE    = 3'd0,
      ACT_SAVE    = 3'd1,
      ACT_LOAD    = 3'd2,
      ACT_STORE   = 3'd3,
      ACT_RESTORE = 3'd4
   } action_type;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_MERGE,
      ST_SPILL,
      ST_TAKE,
      ST_FLUSH,
      ST_RESTORE,
      ST_FINISH
   } state_type;

   // walk unit command
   typedef struct packed {
      logic              load;
      logic              step;
      logic [WALK_W-1:0] start;
      logic [WALK_W-1:0] limit;
   } walk_cmd_type;

   // one move as it leaves the block
   typedef struct packed {
      action_type            action;
      logic [GUEST_W-1:0]    guest_reg;
      logic [SLOT_OUT_W-1:0] host_slot;
   } move_type;

   typedef struct packed {
      logic     valid;
      move_type move;
   } emit_type;

endpackage

[src/guest_register_cache_allocator.sv]
// ----------------------------------------------------------------------------
// guest_register_cache_allocator
// Maps guest registers onto host slots with a bump pointer, emitting the
// save, load, store and restore moves, when the output is free, at most one per cycle
// ----------------------------------------------------------------------------
// Steps to the last result in the output register: mark dirty finishes at once;
//   allocate merges, spills when it does not fit, then takes; call spills the
//   volatile slots when needed; flush stores, then restores; output stalls add.
// Throughput: one item at a time, at most one move per cycle while the output
//   is free, set by the single walk unit that steps slots and guest registers likewise.
// Reset: synchronous; clears mapped and dirty bits, slot valid, saved bits and the pointer.
`timescale 1ns / 1ps
`include "assert_macros.svh"

module guest_register_cache_allocator #(
   parameter int HOST_SLOTS      = gurc_pkg::HOST_SLOTS_DEF,
   parameter int PRESERVED_SLOTS = gurc_pkg::PRESERVED_SLOTS_DEF
) (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              req_valid,
   output logic                              req_stall,
   input  logic [1:0]                        req_op,
   input  logic [gurc_pkg::GUEST_W-1:0]      req_reg_a,
   input  logic [gurc_pkg::GUEST_W-1:0]      req_reg_b,
   input  logic [gurc_pkg::GUEST_W-1:0]      req_reg_c,
   input  logic [1:0]                        req_reg_count,
   output logic                              rsp_valid,
   input  logic                              rsp_stall,
   output logic [2:0]                        rsp_action,
   output logic [gurc_pkg::GUEST_W-1:0]      rsp_guest_reg,
   output logic [gurc_pkg::SLOT_OUT_W-1:0]   rsp_host_slot,
   output logic                              rsp_last
);
   import gurc_pkg::*;

   localparam int SLOT_W   = $clog2(HOST_SLOTS);
   localparam int OWN_N    = 1 << SLOT_W;
   localparam int NEXT_W   = $clog2(HOST_SLOTS + 1);
   localparam int PRES_EFF = (PRESERVED_SLOTS < HOST_SLOTS) ? PRESERVED_SLOTS : HOST_SLOTS;
   localparam int SAVED_IW = (PRES_EFF > 2) ? $clog2(PRES_EFF) : 1;
   localparam int SAVED_N  = 1 << SAVED_IW;

   // sequencer and item registers
   state_type          state_ff, state_in;
   op_type             op_ff;
   logic [GUEST_W-1:0] reg_a_ff, reg_b_ff, reg_c_ff;
   logic [1:0]         cnt_ff;
   logic [GUEST_W-1:0] uniq_ff [4];
   logic [1:0]         n_ff;
   logic [1:0]         k_ff, k_in;

   // cache state
   logic [GUEST_REGS-1:0] mapped_ff, mapped_in;
   logic [GUEST_REGS-1:0] dirty_ff, dirty_in;
   logic [SLOT_W-1:0]     gslot_ff [GUEST_REGS];
   logic [SLOT_W-1:0]     gslot_in [GUEST_REGS];
   logic [OWN_N-1:0]      own_valid_ff, own_valid_in;
   logic [GUEST_W-1:0]    own_guest_ff [OWN_N];
   logic [GUEST_W-1:0]    own_guest_in [OWN_N];
   logic [SAVED_N-1:0]    saved_ff, saved_in;
   logic [NEXT_W-1:0]     next_ff, next_in;

   // shared walk unit and result stage
   walk_cmd_type       walk_cmd;
   logic [WALK_W-1:0]  walk_idx;
   logic               walk_more;
   emit_type           emit;
   logic               fin;
   logic               out_free;

   logic req_fire;
   logic do_mark, do_merge, do_spill_clr, do_spill_end;
   logic do_take_save, do_take_load, do_restore_clr, do_clear_all;

   assign req_stall = (state_ff != ST_IDLE);
   assign req_fire  = req_valid && !req_stall;

   // widened views of the pointer and the walk index
   logic [WALK_W-1:0]   next_ext;
   logic [SLOT_W-1:0]   next_slot;
   logic [SLOT_W-1:0]   sp_slot;
   logic [GUEST_W-1:0]  sp_guest;
   logic [GUEST_W-1:0]  fl_guest;
   logic [WALK_W-1:0]   fl_slot_ext;
   logic [SAVED_IW-1:0] wk_saved_idx;
   logic [SAVED_IW-1:0] nx_saved_idx;
   logic [GUEST_W-1:0]  tk_guest;
   logic                tk_save_need;
   logic                call_spill;

   assign next_ext     = WALK_W'(next_ff);
   assign next_slot    = next_ext[SLOT_W-1:0];
   assign sp_slot      = walk_idx[SLOT_W-1:0];
   assign sp_guest     = own_guest_ff[sp_slot];
   assign fl_guest     = walk_idx[GUEST_W-1:0];
   assign fl_slot_ext  = WALK_W'(gslot_ff[fl_guest]);
   assign wk_saved_idx = walk_idx[SAVED_IW-1:0];
   assign nx_saved_idx = next_ext[SAVED_IW-1:0];
   assign tk_guest     = uniq_ff[k_ff];
   assign tk_save_need = (next_ext < WALK_W'(PRES_EFF)) && !saved_ff[nx_saved_idx];
   assign call_spill   = (next_ext > WALK_W'(PRES_EFF));

   // duplicate merge and fit check of the latched request
   logic               tk_b, tk_c;
   logic [1:0]         m_n;
   logic [1:0]         m_need;
   logic [GUEST_W-1:0] m_u1;
   logic               m_spill;

   always_comb begin
      tk_b    = (cnt_ff >= 2'd2) && (reg_b_ff != reg_a_ff);
      tk_c    = (cnt_ff == 2'd3) && (reg_c_ff != reg_a_ff) && !(tk_b && (reg_c_ff == reg_b_ff));
      m_u1    = tk_b ? reg_b_ff : reg_c_ff;
      m_n     = {1'b0, (cnt_ff != 2'd0)} + {1'b0, tk_b} + {1'b0, tk_c};
      m_need  = {1'b0, (m_n >= 2'd1) && !mapped_ff[reg_a_ff]}
              + {1'b0, (m_n >= 2'd2) && !mapped_ff[m_u1]}
              + {1'b0, (m_n == 2'd3) && !mapped_ff[reg_c_ff]};
      m_spill = (m_need != 2'd0) && ((next_ext + WALK_W'(m_need)) > WALK_W'(HOST_SLOTS));
   end

   // next state
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         ST_IDLE: begin
            if (req_fire) begin
               case (op_type'(req_op))
                  OP_ALLOC: state_in = ST_MERGE;
                  OP_DIRTY: state_in = ST_FINISH;
                  OP_CALL:  state_in = call_spill ? ST_SPILL : ST_FINISH;
                  OP_FLUSH: state_in = ST_FLUSH;
                  default:  state_in = ST_FINISH;
               endcase
            end
         end
         ST_MERGE:   state_in = m_spill ? ST_SPILL : ST_TAKE;
         ST_SPILL: begin
            if (!walk_more) state_in = (op_ff == OP_ALLOC) ? ST_TAKE : ST_FINISH;
         end
         ST_TAKE: begin
            if (k_ff >= n_ff) state_in = ST_FINISH;
         end
         ST_FLUSH: begin
            if (!walk_more) state_in = ST_RESTORE;
         end
         ST_RESTORE: begin
            if (!walk_more) state_in = ST_FINISH;
         end
         ST_FINISH: begin
            if (out_free) state_in = ST_IDLE;
         end
         default: state_in = ST_IDLE;
      endcase
   end

   // sequencer outputs
   always_comb begin
      walk_cmd       = '0;
      emit           = '0;
      fin            = 1'b0;
      do_mark        = 1'b0;
      do_merge       = 1'b0;
      do_spill_clr   = 1'b0;
      do_spill_end   = 1'b0;
      do_take_save   = 1'b0;
      do_take_load   = 1'b0;
      do_restore_clr = 1'b0;
      do_clear_all   = 1'b0;
      k_in           = k_ff;
      case (state_ff)
         ST_IDLE: begin
            if (req_fire) begin
               case (op_type'(req_op))
                  OP_DIRTY: do_mark = 1'b1;
                  OP_CALL: begin
                     walk_cmd.load  = call_spill;
                     walk_cmd.start = WALK_W'(PRES_EFF);
                     walk_cmd.limit = next_ext;
                  end
                  OP_FLUSH: begin
                     walk_cmd.load  = 1'b1;
                     walk_cmd.start = WALK_W'(1);
                     walk_cmd.limit = WALK_W'(GUEST_REGS);
                  end
                  default: ;
               endcase
            end
         end
         ST_MERGE: begin
            do_merge       = 1'b1;
            k_in           = 2'd0;
            walk_cmd.load  = m_spill;
            walk_cmd.start = '0;
            walk_cmd.limit = next_ext;
         end
         // store dirty owners and release each slot of the range
         ST_SPILL: begin
            if (walk_more) begin
               if (own_valid_ff[sp_slot] && dirty_ff[sp_guest]) begin
                  if (out_free) begin
                     emit.valid          = 1'b1;
                     emit.move.action    = ACT_STORE;
                     emit.move.guest_reg = sp_guest;
                     emit.move.host_slot = walk_idx[SLOT_OUT_W-1:0];
                     do_spill_clr        = 1'b1;
                     walk_cmd.step       = 1'b1;
                  end
               end else begin
                  do_spill_clr  = own_valid_ff[sp_slot];
                  walk_cmd.step = 1'b1;
               end
            end else begin
               do_spill_end = 1'b1;
            end
         end
         // map each unmapped merged register at the pointer, saving a preserved slot first where needed
         ST_TAKE: begin
            if (k_ff < n_ff) begin
               if (mapped_ff[tk_guest] || (next_ext >= WALK_W'(HOST_SLOTS))) begin
                  k_in = k_ff + 2'd1;
               end else if (out_free) begin
                  emit.valid          = 1'b1;
                  emit.move.host_slot = next_ext[SLOT_OUT_W-1:0];
                  if (tk_save_need) begin
                     emit.move.action    = ACT_SAVE;
                     emit.move.guest_reg = '0;
                     do_take_save        = 1'b1;
                  end else begin
                     emit.move.action    = ACT_LOAD;
                     emit.move.guest_reg = tk_guest;
                     do_take_load        = 1'b1;
                     k_in                = k_ff + 2'd1;
                  end
               end
            end
         end
         // store dirty mapped registers in guest order, from guest register 1 upward
         ST_FLUSH: begin
            if (walk_more) begin
               if (mapped_ff[fl_guest] && dirty_ff[fl_guest]) begin
                  if (out_free) begin
                     emit.valid          = 1'b1;
                     emit.move.action    = ACT_STORE;
                     emit.move.guest_reg = fl_guest;
                     emit.move.host_slot = fl_slot_ext[SLOT_OUT_W-1:0];
                     walk_cmd.step       = 1'b1;
                  end
               end else begin
                  walk_cmd.step = 1'b1;
               end
            end else begin
               walk_cmd.load  = 1'b1;
               walk_cmd.start = '0;
               walk_cmd.limit = WALK_W'(PRES_EFF);
            end
         end
         // restore saved preserved slots, then drop the whole table
         ST_RESTORE: begin
            if (walk_more) begin
               if (saved_ff[wk_saved_idx]) begin
                  if (out_free) begin
                     emit.valid          = 1'b1;
                     emit.move.action    = ACT_RESTORE;
                     emit.move.guest_reg = '0;
                     emit.move.host_slot = walk_idx[SLOT_OUT_W-1:0];
                     do_restore_clr      = 1'b1;
                     walk_cmd.step       = 1'b1;
                  end
               end else begin
                  walk_cmd.step = 1'b1;
               end
            end else begin
               do_clear_all = 1'b1;
            end
         end
         ST_FINISH: fin = out_free;
         default: ;
      endcase
   end

   // cache state update
   always_comb begin
      mapped_in    = mapped_ff;
      dirty_in     = dirty_ff;
      gslot_in     = gslot_ff;
      own_valid_in = own_valid_ff;
      own_guest_in = own_guest_ff;
      saved_in     = saved_ff;
      next_in      = next_ff;
      if (do_mark && mapped_ff[req_reg_a]) begin
         dirty_in[req_reg_a] = 1'b1;
      end
      if (do_spill_clr) begin
         mapped_in[sp_guest]   = 1'b0;
         dirty_in[sp_guest]    = 1'b0;
         own_valid_in[sp_slot] = 1'b0;
      end
      if (do_spill_end) begin
         next_in = (op_ff == OP_ALLOC) ? '0 : NEXT_W'(PRES_EFF);
      end
      if (do_take_save) begin
         saved_in[nx_saved_idx] = 1'b1;
      end
      if (do_take_load) begin
         mapped_in[tk_guest]     = 1'b1;
         dirty_in[tk_guest]      = 1'b0;
         gslot_in[tk_guest]      = next_slot;
         own_valid_in[next_slot] = 1'b1;
         own_guest_in[next_slot] = tk_guest;
         next_in                 = next_ff + NEXT_W'(1);
      end
      if (do_restore_clr) begin
         saved_in[wk_saved_idx] = 1'b0;
      end
      if (do_clear_all) begin
         mapped_in    = '0;
         dirty_in     = '0;
         own_valid_in = '0;
         next_in      = '0;
      end
   end

   // control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         k_ff         <= '0;
         mapped_ff    <= '0;
         dirty_ff     <= '0;
         own_valid_ff <= '0;
         saved_ff     <= '0;
         next_ff      <= '0;
      end else begin
         state_ff     <= state_in;
         k_ff         <= k_in;
         mapped_ff    <= mapped_in;
         dirty_ff     <= dirty_in;
         own_valid_ff <= own_valid_in;
         saved_ff     <= saved_in;
         next_ff      <= next_in;
      end
   end

   // payload registers
   always_ff @(posedge clock) begin
      gslot_ff     <= gslot_in;
      own_guest_ff <= own_guest_in;
      if (req_fire) begin
         op_ff    <= op_type'(req_op);
         reg_a_ff <= req_reg_a;
         reg_b_ff <= req_reg_b;
         reg_c_ff <= req_reg_c;
         cnt_ff   <= req_reg_count;
      end
      if (do_merge) begin
         uniq_ff[0] <= reg_a_ff;
         uniq_ff[1] <= m_u1;
         uniq_ff[2] <= reg_c_ff;
         uniq_ff[3] <= '0;
         n_ff       <= m_n;
      end
   end

   gurc_walk u_walk (
      .clock (clock),
      .reset (reset),
      .cmd   (walk_cmd),
      .idx   (walk_idx),
      .more  (walk_more)
   );

   gurc_out u_out (
      .clock         (clock),
      .reset         (reset),
      .emit          (emit),
      .fin           (fin),
      .free          (out_free),
      .rsp_valid     (rsp_valid),
      .rsp_stall     (rsp_stall),
      .rsp_action    (rsp_action),
      .rsp_guest_reg (rsp_guest_reg),
      .rsp_host_slot (rsp_host_slot),
      .rsp_last      (rsp_last)
   );

   // mapped guest count equals valid slot count
   `ASSERT_ALWAYS(a_map_count, clock, reset, $countones(mapped_ff) == $countones(own_valid_ff), "mapped guest count differs from valid slot count")
   // no valid slot at or above the bump pointer
   `ASSERT_ALWAYS(a_valid_below_next, clock, reset, (own_valid_ff >> next_ff) == '0, "valid slot above the bump pointer")
   // pointer never runs past the slot count
   `ASSERT_ALWAYS(a_next_range, clock, reset, WALK_W'(next_ff) <= WALK_W'(HOST_SLOTS), "bump pointer out of range")
   // an accepted transfer keeps the input side busy in the next cycle
   `ASSERT_NEXT(a_busy_after_accept, clock, reset, req_fire, req_stall, "input not stalled after transfer")

endmodule

[src/gurc_walk.sv]
// ----------------------------------------------------------------------------
// gurc_walk
// Shared index unit: one counter, incrementer and limit compare used by the
// spill, flush and restore walks
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module gurc_walk (
   input  logic                          clock,
   input  logic                          reset,
   input  gurc_pkg::walk_cmd_type        cmd,
   output logic [gurc_pkg::WALK_W-1:0]   idx,
   output logic                          more
);
   import gurc_pkg::*;

   logic [WALK_W-1:0] idx_ff, idx_in;
   logic [WALK_W-1:0] lim_ff, lim_in;

   // load a new range or step one index
   always_comb begin
      idx_in = idx_ff;
      lim_in = lim_ff;
      if (cmd.load) begin
         idx_in = cmd.start;
         lim_in = cmd.limit;
      end else if (cmd.step) begin
         idx_in = idx_ff + WALK_W'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         idx_ff <= '0;
         lim_ff <= '0;
      end else begin
         idx_ff <= idx_in;
         lim_ff <= lim_in;
      end
   end

   assign idx  = idx_ff;
   assign more = (idx_ff < lim_ff);

endmodule

[src/gurc_out.sv]
// ----------------------------------------------------------------------------
// gurc_out
// Result stage: a hold register keeps the newest move until the next one or
// the end of the item decides its last flag, then an output register drives
// the result channel
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module gurc_out (
   input  logic                              clock,
   input  logic                              reset,
   input  gurc_pkg::emit_type                emit,
   input  logic                              fin,
   output logic                              free,
   output logic                              rsp_valid,
   input  logic                              rsp_stall,
   output logic [2:0]                        rsp_action,
   output logic [gurc_pkg::GUEST_W-1:0]      rsp_guest_reg,
   output logic [gurc_pkg::SLOT_OUT_W-1:0]   rsp_host_slot,
   output logic                              rsp_last
);
   import gurc_pkg::*;

   logic     hold_valid_ff, hold_valid_in;
   move_type hold_ff, hold_in;
   logic     rsp_valid_ff, rsp_valid_in;
   move_type rsp_ff, rsp_in;
   logic     rsp_last_ff, rsp_last_in;
   move_type none_move;

   assign none_move = '{action: ACT_NONE, guest_reg: '0, host_slot: '0};

   // output register can take a move this cycle
   assign free = !rsp_valid_ff || !rsp_stall;

   // hold and output register update
   always_comb begin
      hold_valid_in = hold_valid_ff;
      hold_in       = hold_ff;
      rsp_valid_in  = rsp_valid_ff && rsp_stall;
      rsp_in        = rsp_ff;
      rsp_last_in   = rsp_last_ff;
      if (emit.valid) begin
         if (hold_valid_ff) begin
            rsp_valid_in = 1'b1;
            rsp_in       = hold_ff;
            rsp_last_in  = 1'b0;
         end
         hold_valid_in = 1'b1;
         hold_in       = emit.move;
      end else if (fin) begin
         rsp_valid_in  = 1'b1;
         rsp_in        = hold_valid_ff ? hold_ff : none_move;
         rsp_last_in   = 1'b1;
         hold_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         hold_valid_ff <= 1'b0;
         rsp_valid_ff  <= 1'b0;
      end else begin
         hold_valid_ff <= hold_valid_in;
         rsp_valid_ff  <= rsp_valid_in;
      end
   end

   // payload registers
   always_ff @(posedge clock) begin
      hold_ff     <= hold_in;
      rsp_ff      <= rsp_in;
      rsp_last_ff <= rsp_last_in;
   end

   assign rsp_valid     = rsp_valid_ff;
   assign rsp_action    = rsp_ff.action;
   assign rsp_guest_reg = rsp_ff.guest_reg;
   assign rsp_host_slot = rsp_ff.host_slot;
   assign rsp_last      = rsp_last_ff;

endmodule
